@@ sv/gfg_pkg.sv @@
`timescale 1ns / 1ps
package gfg_pkg;

  localparam int GAIN_W    = 48;
  localparam int POS_W     = 17;
  localparam int RGBA_W    = 32;
  localparam int IDX_W     = 3;
  localparam int PIX_W     = 12;
  localparam int CH_W      = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 4;
  // gradient coordinate: unsigned, 32 fraction bits, capped at 131071/65536
  localparam int T_W       = 33;
  localparam logic [T_W-1:0] T_MAX = {17'h1FFFF, 16'h0000};

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_GAIN_X     = 3'd1,
    REG_GAIN_Y     = 3'd2,
    REG_OFFSET_X   = 3'd3,
    REG_OFFSET_Y   = 3'd4,
    REG_STOP_COUNT = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SH_ZERO,
    SH_LO,
    SH_SEG
  } shade_kind_t;

  typedef struct packed {
    logic              opcode;
    logic [IDX_W-1:0]  stop_index;
    logic [POS_W-1:0]  stop_pos;
    logic [RGBA_W-1:0] stop_rgba;
  } load_t;

endpackage

@@ sv/gfg_cmd_if.sv @@
`timescale 1ns / 1ps
interface gfg_cmd_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [gfg_pkg::IDX_W-1:0]   stop_index;
  logic [gfg_pkg::POS_W-1:0]   stop_pos;
  logic [gfg_pkg::RGBA_W-1:0]  stop_rgba;
  logic [gfg_pkg::PIX_W-1:0]   pixel_x;
  logic [gfg_pkg::PIX_W-1:0]   pixel_y;

  modport source (
    output valid, opcode, stop_index, stop_pos, stop_rgba, pixel_x, pixel_y,
    input  ready
  );
  modport sink (
    input  valid, opcode, stop_index, stop_pos, stop_rgba, pixel_x, pixel_y,
    output ready
  );
endinterface

@@ sv/gfg_cfg_if.sv @@
`timescale 1ns / 1ps
interface gfg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gfg_pkg::CFG_IDX_W-1:0] index;
  logic [gfg_pkg::GAIN_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/gfg_color_if.sv @@
`timescale 1ns / 1ps
interface gfg_color_if;
  logic                      valid;
  logic                      ready;
  logic [gfg_pkg::CH_W-1:0]  color_red;
  logic [gfg_pkg::CH_W-1:0]  color_green;
  logic [gfg_pkg::CH_W-1:0]  color_blue;
  logic [gfg_pkg::CH_W-1:0]  color_alpha;

  modport source (
    output valid, color_red, color_green, color_blue, color_alpha,
    input  ready
  );
  modport sink (
    input  valid, color_red, color_green, color_blue, color_alpha,
    output ready
  );
endinterface

@@ sv/gfg_ram.sv @@
`timescale 1ns / 1ps
module gfg_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/gradient_fill_generator.sv @@
`timescale 1ns / 1ps
// Channel  Modport  Payload                                          Request moves when
// cmd      sink     opcode, stop_index, stop_pos, stop_rgba, x, y    valid & ready
// cfg      sink     index (3b), data (48b)                           valid & ready (always ready)
// color    source   color_red, color_green, color_blue, color_alpha  valid & ready
//
// One request per cycle enters while the color output is not stalled; each pixel request yields a result.
// Depth is set by the 28-step square root (7 stages of 4 steps) and the 8-bit
// quotient of the interpolation (2 stages of 4 steps).
// A stalled color output freezes every stage together; nothing is lost or repeated.
// rst is synchronous, clears config registers and all valid bits. The stop table is
// not cleared.
module gradient_fill_generator #(
  parameter int MAX_STOPS  = 8,
  parameter int COORD_BITS = 12
) (
  input logic       clk,
  input logic       rst,
  gfg_cmd_if.sink   cmd,
  gfg_cfg_if.sink   cfg,
  gfg_color_if.source color
);

  localparam int AW     = $clog2(MAX_STOPS);
  localparam int NW     = $clog2(MAX_STOPS + 1);
  localparam int CB     = COORD_BITS;
  localparam int PPW    = CB + 24;
  localparam int POS_W  = gfg_pkg::POS_W;
  localparam int T_W    = gfg_pkg::T_W;
  localparam int CH_W   = gfg_pkg::CH_W;
  localparam int ENT_W  = gfg_pkg::POS_W + gfg_pkg::RGBA_W;
  localparam int SQ_N   = 7;
  localparam int SQ_IN  = 56;
  localparam int RT_W   = 27;
  localparam int RM_W   = 31;
  localparam int YW     = 44;
  localparam int LD_N   = 14;

  typedef struct packed {
    logic [RM_W-1:0] rem;
    logic [RT_W-1:0] root;
  } sq_t;

  // ---------------------------------------------------------------- helpers
  // clamp a 65-bit exact sum to the int64 range
  function automatic logic [63:0] sat64(input logic [64:0] s);
    logic [63:0] r;
    if (s[64] != s[63]) begin
      r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  // magnitude, capped at 4.0, down to 24 fraction bits
  function automatic logic [RT_W-1:0] mag_q(input logic [63:0] v);
    logic [63:0] m;
    m = v[63] ? (64'd0 - v) : v;
    if (m > 64'h4_0000_0000) begin
      m = 64'h4_0000_0000;
    end
    return m[34:8];
  endfunction

  function automatic logic [T_W-1:0] clamp_lin(input logic [63:0] s);
    logic [T_W-1:0] r;
    if (s[63]) begin
      r = '0;
    end else if (s > 64'(gfg_pkg::T_MAX)) begin
      r = gfg_pkg::T_MAX;
    end else begin
      r = s[T_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [T_W-1:0] clamp_rad(input logic [RT_W-1:0] root);
    logic [RT_W+7:0] w;
    logic [T_W-1:0]  r;
    w = {root, 8'd0};
    if (w > (RT_W+8)'(gfg_pkg::T_MAX)) begin
      r = gfg_pkg::T_MAX;
    end else begin
      r = w[T_W-1:0];
    end
    return r;
  endfunction

  // four steps of the digit-by-digit square root, two radicand bits a step
  function automatic sq_t sq_step(input sq_t s, input logic [7:0] pairs);
    sq_t             r;
    logic [RM_W-1:0] cur;
    logic [RM_W-1:0] trial;
    r = s;
    for (int k = 3; k >= 0; k--) begin
      cur   = {r.rem[RM_W-3:0], pairs[2*k +: 2]};
      trial = RM_W'({r.root, 2'b01});
      if (cur >= trial) begin
        r.rem  = cur - trial;
        r.root = {r.root[RT_W-2:0], 1'b1};
      end else begin
        r.rem  = cur;
        r.root = {r.root[RT_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // four restoring division steps, quotient bits base+3 .. base
  function automatic logic [YW+3:0] div4(input logic [YW-1:0] rem_in,
                                         input logic [YW-1:0] dvz, input int base);
    logic [YW-1:0] r;
    logic [YW-1:0] sh;
    logic [3:0]    q;
    r = rem_in;
    q = '0;
    for (int k = 3; k >= 0; k--) begin
      sh = dvz << (base + k);
      if (r >= sh) begin
        r    = r - sh;
        q[k] = 1'b1;
      end
    end
    return {r, q};
  endfunction

  // ---------------------------------------------------------------- config
  logic                          mode;
  logic [gfg_pkg::GAIN_W-1:0]    gain_x;
  logic [gfg_pkg::GAIN_W-1:0]    gain_y;
  logic [gfg_pkg::GAIN_W-1:0]    offset_x;
  logic [gfg_pkg::GAIN_W-1:0]    offset_y;
  logic [gfg_pkg::CNT_W-1:0]     stop_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      gain_x     <= '0;
      gain_y     <= '0;
      offset_x   <= '0;
      offset_y   <= '0;
      stop_count <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        gfg_pkg::REG_MODE:       mode       <= cfg.data[0];
        gfg_pkg::REG_GAIN_X:     gain_x     <= cfg.data;
        gfg_pkg::REG_GAIN_Y:     gain_y     <= cfg.data;
        gfg_pkg::REG_OFFSET_X:   offset_x   <= cfg.data;
        gfg_pkg::REG_OFFSET_Y:   offset_y   <= cfg.data;
        gfg_pkg::REG_STOP_COUNT: stop_count <= cfg.data[gfg_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [64:0] ox65;
  logic [64:0] oy65;
  assign ox65 = {{17{offset_x[47]}}, offset_x};
  assign oy65 = {{17{offset_y[47]}}, offset_y};

  // ---------------------------------------------------------------- flow control
  // All stages advance together; the output register is the only place that waits.
  logic out_v;
  logic en;
  assign en        = !out_v || color.ready;
  assign cmd.ready = en;

  logic [LD_N:1]   vp;
  gfg_pkg::load_t  ld_pipe [1:LD_N];
  logic            v15, v16, v17, v18, v19;

  // ---------------------------------------------------------------- coordinate stages
  logic [CB-1:0]          x_in, y_in;
  logic signed [PPW-1:0]  pxh1, pyh1;
  logic [PPW-1:0]         pxl1, pyl1;
  logic [63:0]            px2, py2;
  logic [63:0]            l1_3, dx3, dy3;
  logic [63:0]            l2_4;
  logic [RT_W-1:0]        mx4, my4;
  logic [T_W-1:0]         tl5;
  logic [2*RT_W-1:0]      sx5, sy5;

  // square-root pipe; entry 0 is the radicand stage
  sq_t                    sq_s   [0:SQ_N];
  logic [SQ_IN-1:0]       sq_val [0:SQ_N];
  logic [T_W-1:0]         sq_tl  [0:SQ_N];

  assign x_in = CB'(cmd.pixel_x);
  assign y_in = CB'(cmd.pixel_y);

  always_ff @(posedge clk) begin
    if (en) begin
      // gains split into a signed upper and an unsigned lower half
      pxh1 <= $signed({1'b0, x_in}) * $signed(gain_x[47:24]);
      pxl1 <= x_in * gain_x[23:0];
      pyh1 <= $signed({1'b0, y_in}) * $signed(gain_y[47:24]);
      pyl1 <= y_in * gain_y[23:0];

      px2 <= ({{(64-PPW){pxh1[PPW-1]}}, pxh1} << 24) + {{(64-PPW){1'b0}}, pxl1};
      py2 <= ({{(64-PPW){pyh1[PPW-1]}}, pyh1} << 24) + {{(64-PPW){1'b0}}, pyl1};

      l1_3 <= sat64({px2[63], px2} + {py2[63], py2});
      dx3  <= sat64({px2[63], px2} - ox65);
      dy3  <= sat64({py2[63], py2} - oy65);

      l2_4 <= sat64({l1_3[63], l1_3} - ox65);
      mx4  <= mag_q(dx3);
      my4  <= mag_q(dy3);

      tl5  <= clamp_lin(sat64({l2_4[63], l2_4} - oy65));
      sx5  <= mx4 * mx4;
      sy5  <= my4 * my4;

      sq_s[0]   <= '0;
      sq_val[0] <= {2'b00, sx5 + sy5};
      sq_tl[0]  <= tl5;
      for (int j = 0; j < SQ_N; j++) begin
        sq_s[j+1]   <= sq_step(sq_s[j], sq_val[j][SQ_IN-1-8*j -: 8]);
        sq_val[j+1] <= sq_val[j];
        sq_tl[j+1]  <= sq_tl[j];
      end

      ld_pipe[1] <= '{opcode: cmd.opcode, stop_index: cmd.stop_index,
                      stop_pos: cmd.stop_pos, stop_rgba: cmd.stop_rgba};
      for (int k = 2; k <= LD_N; k++) begin
        ld_pipe[k] <= ld_pipe[k-1];
      end
    end
  end

  // ---------------------------------------------------------------- stop table
  // t14 lines up with ld_pipe[14]. Loads write here, at the first stage that reads
  // the table, so each pixel sees exactly the stops loaded before it.
  logic [T_W-1:0]    t14;
  logic [POS_W-1:0]  pos_lane [MAX_STOPS];
  logic              wr14;
  logic [AW-1:0]     wa14;

  always_ff @(posedge clk) begin
    if (en) begin
      t14 <= mode ? clamp_rad(sq_s[SQ_N].root) : sq_tl[SQ_N];
    end
  end

  assign wr14 = vp[LD_N] && (ld_pipe[LD_N].opcode == gfg_pkg::OP_LOAD) &&
                ({29'd0, ld_pipe[LD_N].stop_index} < 32'(MAX_STOPS));
  assign wa14 = AW'(ld_pipe[LD_N].stop_index);

  always_ff @(posedge clk) begin
    if (en && wr14) begin
      pos_lane[wa14] <= ld_pipe[LD_N].stop_pos;
    end
  end

  // ---------------------------------------------------------------- stop compare
  logic [NW-1:0]         n14;
  logic                  few14, first14, last14;
  logic [MAX_STOPS-1:0]  le14;
  logic [AW-1:0]         nm1_14;

  always_comb begin
    if ({28'd0, stop_count} > 32'(MAX_STOPS)) begin
      n14 = NW'(MAX_STOPS);
    end else begin
      n14 = NW'(stop_count);
    end
    few14   = n14 < NW'(2);
    nm1_14  = AW'(n14 - NW'(1));
    first14 = t14 <= {pos_lane[0], 16'd0};
    last14  = 1'b0;
    le14    = '0;
    for (int i = 0; i < MAX_STOPS; i++) begin
      if (NW'(i + 1) == n14) begin
        last14 = t14 >= {pos_lane[i], 16'd0};
      end
      if (i >= 1 && NW'(i) < n14) begin
        le14[i] = t14 <= {pos_lane[i], 16'd0};
      end
    end
  end

  logic [T_W-1:0]        t15;
  logic [MAX_STOPS-1:0]  le15;
  logic                  few15, first15, last15;
  logic [AW-1:0]         nm1_15;

  always_ff @(posedge clk) begin
    if (en) begin
      t15     <= t14;
      le15    <= le14;
      few15   <= few14;
      first15 <= first14;
      last15  <= last14;
      nm1_15  <= nm1_14;
    end
  end

  // ---------------------------------------------------------------- segment pick
  gfg_pkg::shade_kind_t kind15;
  logic                 found15;
  logic [AW-1:0]        sel15, lo_a15, hi_a15;

  always_comb begin
    found15 = 1'b0;
    sel15   = '0;
    for (int i = MAX_STOPS - 1; i >= 1; i--) begin
      if (le15[i]) begin
        found15 = 1'b1;
        sel15   = AW'(i);
      end
    end
    lo_a15 = '0;
    hi_a15 = '0;
    if (few15) begin
      kind15 = gfg_pkg::SH_ZERO;
    end else if (first15) begin
      kind15 = gfg_pkg::SH_LO;
    end else if (last15) begin
      kind15 = gfg_pkg::SH_LO;
      lo_a15 = nm1_15;
    end else if (found15) begin
      kind15 = gfg_pkg::SH_SEG;
      lo_a15 = sel15 - AW'(1);
      hi_a15 = sel15;
    end else begin
      kind15 = gfg_pkg::SH_LO;
      lo_a15 = nm1_15;
    end
  end

  // two copies of the table: one read port each, for the lower and upper stop
  logic [ENT_W-1:0] lo_q, hi_q;
  logic [ENT_W-1:0] wdata14;
  assign wdata14 = {ld_pipe[LD_N].stop_pos, ld_pipe[LD_N].stop_rgba};

  gfg_ram #(.WIDTH(ENT_W), .DEPTH(MAX_STOPS)) u_ram_lo (
    .clk   (clk),
    .we    (en && wr14),
    .waddr (wa14),
    .wdata (wdata14),
    .re    (en),
    .raddr (lo_a15),
    .rdata (lo_q)
  );

  gfg_ram #(.WIDTH(ENT_W), .DEPTH(MAX_STOPS)) u_ram_hi (
    .clk   (clk),
    .we    (en && wr14),
    .waddr (wa14),
    .wdata (wdata14),
    .re    (en),
    .raddr (hi_a15),
    .rdata (hi_q)
  );

  gfg_pkg::shade_kind_t kind16;
  logic [T_W-1:0]       t16;

  always_ff @(posedge clk) begin
    if (en) begin
      kind16 <= kind15;
      t16    <= t15;
    end
  end

  // ---------------------------------------------------------------- interpolation
  logic [POS_W-1:0]          plo, phi;
  logic [gfg_pkg::RGBA_W-1:0] clo, chi;
  logic                      interp16;
  logic [T_W-1:0]            d16, den16;

  assign plo = lo_q[ENT_W-1 -: POS_W];
  assign phi = hi_q[ENT_W-1 -: POS_W];
  assign clo = lo_q[gfg_pkg::RGBA_W-1:0];
  assign chi = hi_q[gfg_pkg::RGBA_W-1:0];
  // a segment that does not rise, or a t left of it, takes the lower colour
  assign interp16 = (kind16 == gfg_pkg::SH_SEG) && (phi > plo) && (t16 >= {plo, 16'd0});
  assign d16      = t16 - {plo, 16'd0};
  assign den16    = {phi - plo, 16'd0};

  logic [CH_W+T_W-1:0]          pa17 [4];
  logic signed [CH_W+T_W+1:0]   pd17 [4];
  logic [T_W-1:0]               den17;
  logic                         interp17, zero17;
  logic [gfg_pkg::RGBA_W-1:0]   clo17;
  logic [CH_W:0]                diff16 [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      diff16[c] = {1'b0, chi[8*c +: 8]} - {1'b0, clo[8*c +: 8]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        pa17[c] <= clo[8*c +: 8] * den16;
        pd17[c] <= $signed(diff16[c]) * $signed({1'b0, d16});
      end
      den17    <= den16;
      interp17 <= interp16;
      zero17   <= (kind16 == gfg_pkg::SH_ZERO);
      clo17    <= clo;
    end
  end

  // y = 2*a*den + 2*(b-a)*d + den, never negative; result = y / (2*den)
  logic [45:0]                y17 [4];
  logic [YW-1:0]              y18 [4];
  logic [T_W:0]               dv18;
  logic                       interp18, zero18;
  logic [gfg_pkg::RGBA_W-1:0] clo18;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      y17[c] = {4'd0, pa17[c], 1'b0} + {{2{pd17[c][CH_W+T_W+1]}}, pd17[c], 1'b0} +
               {13'd0, den17};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        y18[c] <= y17[c][YW-1:0];
      end
      dv18     <= {den17, 1'b0};
      interp18 <= interp17;
      zero18   <= zero17;
      clo18    <= clo17;
    end
  end

  logic [YW-1:0]              rem19 [4];
  logic [3:0]                 qh19  [4];
  logic                       interp19, zero19;
  logic [gfg_pkg::RGBA_W-1:0] clo19;
  logic [YW+3:0]              dh18  [4];
  logic [YW+3:0]              dl19  [4];
  logic [T_W:0]               dv18_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      dh18[c] = div4(y18[c], YW'(dv18), 4);
      dl19[c] = div4(rem19[c], YW'(dv18_q), 0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        rem19[c] <= dh18[c][YW+3:4];
        qh19[c]  <= dh18[c][3:0];
      end
      dv18_q   <= dv18;
      interp19 <= interp18;
      zero19   <= zero18;
      clo19    <= clo18;
    end
  end

  // ---------------------------------------------------------------- output register
  logic [CH_W-1:0] ch_next [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (zero19) begin
        ch_next[c] = '0;
      end else if (interp19) begin
        ch_next[c] = {qh19[c], dl19[c][3:0]};
      end else begin
        ch_next[c] = clo19[8*c +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      color.color_red   <= ch_next[0];
      color.color_green <= ch_next[1];
      color.color_blue  <= ch_next[2];
      color.color_alpha <= ch_next[3];
    end
  end

  assign color.valid = out_v;

  // ---------------------------------------------------------------- valid bits
  // Loads leave the pipe after the table write; only pixels go on.
  always_ff @(posedge clk) begin
    if (rst) begin
      vp    <= '0;
      v15   <= 1'b0;
      v16   <= 1'b0;
      v17   <= 1'b0;
      v18   <= 1'b0;
      v19   <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      vp    <= {vp[LD_N-1:1], cmd.valid};
      v15   <= vp[LD_N] && (ld_pipe[LD_N].opcode == gfg_pkg::OP_PIXEL);
      v16   <= v15;
      v17   <= v16;
      v18   <= v17;
      v19   <= v18;
      out_v <= v19;
    end
  end

endmodule

@@ sv/gfg_checker.sv @@
`timescale 1ns / 1ps
module gfg_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      cmd_ready,
  input logic                      cfg_ready,
  input logic                      color_valid,
  input logic                      color_ready,
  input logic [4*gfg_pkg::CH_W-1:0] color_bits
);

  // a waiting result holds still
  a_hold: assert property (@(posedge clk) disable iff (rst)
    color_valid && !color_ready |=> color_valid && $stable(color_bits))
    else $error("colour result changed while stalled");

  // requests are taken whenever the output can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    cmd_ready == (!color_valid || color_ready))
    else $error("cmd ready does not follow output stall");

  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

  // pipeline empty straight after reset
  a_rst: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !color_valid)
    else $error("result valid right after reset");

endmodule

bind gradient_fill_generator gfg_checker u_gfg_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_ready   (cmd.ready),
  .cfg_ready   (cfg.ready),
  .color_valid (color.valid),
  .color_ready (color.ready),
  .color_bits  ({color.color_alpha, color.color_blue, color.color_green, color.color_red})
);

@@ dv/gfg_shade_checker.sv @@
`timescale 1ns / 1ps
module gfg_shade_checker (
  input  logic clk,
  input  logic rst,
  gfg_cmd_if   cmd,
  gfg_cfg_if   cfg,
  gfg_color_if color,
  output int   fails,
  output int   pending,
  output int   shaded
);

  logic                                     mode_q;
  logic signed [gfg_pkg::GAIN_W-1:0]        gx_q, gy_q, ox_q, oy_q;
  logic [gfg_pkg::CNT_W-1:0]                cnt_q;
  logic [gfg_pkg::POS_W-1:0]                pos_tab [8];
  logic [gfg_pkg::RGBA_W-1:0]               col_tab [8];
  logic [gfg_pkg::RGBA_W-1:0]               expected_colors [$];

  // Q.32 gradient coordinate; 66-bit sums cannot overflow, so no int64 clamp is hit
  function automatic logic [63:0] gradient_coord(logic [gfg_pkg::PIX_W-1:0] x,
                                                 logic [gfg_pkg::PIX_W-1:0] y);
    logic signed [65:0] px, py, s, dx, dy;
    logic [65:0] mx, my;
    logic [63:0] t, v, r, cand;
    px = $signed({1'b0, x}) * gx_q;
    py = $signed({1'b0, y}) * gy_q;
    if (mode_q == 1'b0) begin
      s = px + py - ox_q - oy_q;
      t = (s < 0) ? 64'd0 : s[63:0];
    end else begin
      dx = px - ox_q;
      dy = py - oy_q;
      mx = (dx < 0) ? -dx : dx;
      my = (dy < 0) ? -dy : dy;
      if (mx > (66'd1 << 34)) mx = 66'd1 << 34;
      if (my > (66'd1 << 34)) my = 66'd1 << 34;
      mx = mx >> 8;
      my = my >> 8;
      v = mx[63:0] * mx[63:0] + my[63:0] * my[63:0];
      r = 0;
      for (int b = 27; b >= 0; b--) begin
        cand = r | (64'd1 << b);
        if (cand * cand <= v) r = cand;
      end
      t = r << 8;
    end
    if (t > 64'(gfg_pkg::T_MAX)) t = 64'(gfg_pkg::T_MAX);
    return t;
  endfunction

  function automatic logic [gfg_pkg::RGBA_W-1:0] shade_color(logic [63:0] t);
    int n;
    logic [63:0] lo, hi;
    longint d, den, a0, b0, y;
    logic [gfg_pkg::RGBA_W-1:0] res;
    n = (cnt_q > 8) ? 8 : int'(cnt_q);
    if (n < 2) return '0;
    if (t <= {pos_tab[0], 16'h0}) return col_tab[0];
    if (t >= {pos_tab[n-1], 16'h0}) return col_tab[n-1];
    for (int i = 1; i < n; i++) begin
      lo = {pos_tab[i-1], 16'h0};
      hi = {pos_tab[i], 16'h0};
      if (t <= hi) begin
        if (hi <= lo || t < lo) return col_tab[i-1];
        d   = longint'(t - lo);
        den = longint'(hi - lo);
        for (int c = 0; c < 4; c++) begin
          a0 = longint'(col_tab[i-1][8*c +: 8]);
          b0 = longint'(col_tab[i][8*c +: 8]);
          y  = a0 * 2 * den + 2 * (b0 - a0) * d + den;   // round half up
          res[8*c +: 8] = 8'(y / (2 * den));
        end
        return res;
      end
    end
    return col_tab[n-1];
  endfunction

  assign pending = expected_colors.size();

  always @(posedge clk) begin
    logic [gfg_pkg::RGBA_W-1:0] exp_c, got_c;
    if (rst) begin
      mode_q <= 1'b0;
      gx_q <= '0; gy_q <= '0; ox_q <= '0; oy_q <= '0;
      cnt_q <= '0;
      fails <= 0;
      shaded <= 0;
      expected_colors.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (gfg_pkg::cfg_reg_t'(cfg.index))
          gfg_pkg::REG_MODE:       mode_q <= cfg.data[0];
          gfg_pkg::REG_GAIN_X:     gx_q <= cfg.data;
          gfg_pkg::REG_GAIN_Y:     gy_q <= cfg.data;
          gfg_pkg::REG_OFFSET_X:   ox_q <= cfg.data;
          gfg_pkg::REG_OFFSET_Y:   oy_q <= cfg.data;
          gfg_pkg::REG_STOP_COUNT: cnt_q <= cfg.data[gfg_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        if (cmd.opcode == gfg_pkg::OP_LOAD) begin
          pos_tab[cmd.stop_index] <= cmd.stop_pos;
          col_tab[cmd.stop_index] <= cmd.stop_rgba;
        end else begin
          expected_colors.push_back(shade_color(gradient_coord(cmd.pixel_x, cmd.pixel_y)));
        end
      end
      if (color.valid && color.ready) begin
        got_c = {color.color_alpha, color.color_blue, color.color_green, color.color_red};
        shaded <= shaded + 1;
        if (expected_colors.size() == 0) begin
          if (fails < 10) $display("unexpected colour %h at %0t", got_c, $time);
          fails <= fails + 1;
        end else begin
          exp_c = expected_colors.pop_front();
          if (exp_c !== got_c) begin
            if (fails < 10)
              $display("colour mismatch at %0t: expected rgba %h, got %h", $time, exp_c, got_c);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

@@ dv/gradient_fill_generator_tb.sv @@
`timescale 1ns / 1ps
module gradient_fill_generator_tb;

  localparam logic [47:0] GAIN_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] GAIN_MIN = 48'h8000_0000_0000;
  localparam logic [47:0] UNIT_SPAN = 48'd1048832;  // roughly 1.0 over 4095 pixels

  logic clk = 1'b0;
  logic rst = 1'b1;

  gfg_cmd_if   cmd_if ();
  gfg_cfg_if   cfg_if ();
  gfg_color_if color_if ();

  int fails, pending, shaded;
  int tx_idle = 26;
  int rx_idle = 84;
  bit stall_req = 1'b0;
  int n_pixels = 0, n_loads = 0, n_cfg = 0;
  logic [gfg_pkg::POS_W-1:0] pos_mirror [8];

  always #1 clk = ~clk;

  gradient_fill_generator dut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd_if),
    .cfg   (cfg_if),
    .color (color_if)
  );

  gfg_shade_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_if),
    .cfg     (cfg_if),
    .color   (color_if),
    .fails   (fails),
    .pending (pending),
    .shaded  (shaded)
  );

  // colour sink: random back-pressure, plus one long hold-off on request
  initial begin
    color_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        color_if.ready = 1'b0;
        repeat (400) @(negedge clk);
      end
      color_if.ready = (rx_idle == 0) || ($urandom_range(99) >= rx_idle);
    end
  end

  // Offer one request, idling first at random; returns once it has been taken.
  task automatic send_request(logic op, logic [gfg_pkg::IDX_W-1:0] idx,
                              logic [gfg_pkg::POS_W-1:0] pos,
                              logic [gfg_pkg::RGBA_W-1:0] rgba,
                              logic [gfg_pkg::PIX_W-1:0] x,
                              logic [gfg_pkg::PIX_W-1:0] y);
    @(negedge clk);
    while (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
      cmd_if.valid = 1'b0;
      @(negedge clk);
    end
    cmd_if.valid      = 1'b1;
    cmd_if.opcode     = op;
    cmd_if.stop_index = idx;
    cmd_if.stop_pos   = pos;
    cmd_if.stop_rgba  = rgba;
    cmd_if.pixel_x    = x;
    cmd_if.pixel_y    = y;
    do @(posedge clk); while (!cmd_if.ready);
    if (op == gfg_pkg::OP_LOAD) begin
      n_loads++;
      pos_mirror[idx] = pos;
    end else n_pixels++;
  endtask

  task automatic shade_pixel(logic [gfg_pkg::PIX_W-1:0] x, logic [gfg_pkg::PIX_W-1:0] y);
    logic [63:0] r;
    r = {$urandom, $urandom};
    send_request(gfg_pkg::OP_PIXEL, r[gfg_pkg::IDX_W-1:0], r[gfg_pkg::POS_W+2:3],
                 r[63:32], x, y);
  endtask

  task automatic load_stop(logic [gfg_pkg::IDX_W-1:0] idx, logic [gfg_pkg::POS_W-1:0] pos,
                           logic [gfg_pkg::RGBA_W-1:0] rgba);
    logic [31:0] r;
    r = $urandom;
    send_request(gfg_pkg::OP_LOAD, idx, pos, rgba, r[gfg_pkg::PIX_W-1:0],
                 r[2*gfg_pkg::PIX_W-1:gfg_pkg::PIX_W]);
  endtask

  // Drop valid, drain all results, then cover the pipeline depth since loads
  // leave nothing to wait for.
  task automatic settle();
    @(negedge clk);
    cmd_if.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic program_gradient(logic md, logic [47:0] gx, logic [47:0] gy,
                                  logic [47:0] ox, logic [47:0] oy, logic [3:0] cnt);
    logic [47:0] vals [6];
    vals = '{{47'd0, md}, gx, gy, ox, oy, {44'd0, cnt}};
    settle();
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_if.valid = 1'b1;
      cfg_if.index = gfg_pkg::cfg_reg_t'(i);
      cfg_if.data  = vals[i];
      do @(posedge clk); while (!cfg_if.ready);
      n_cfg++;
    end
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic [47:0] pick_gain();
    int k;
    longint g;
    k = $urandom_range(9);
    if (k == 0) return 48'({$urandom, $urandom});
    if (k == 1) return $urandom_range(1) ? GAIN_MAX : GAIN_MIN;
    g = longint'($urandom_range(1 << 21));
    if ($urandom_range(3) == 0) g = -g;
    return g[47:0];
  endfunction

  task automatic random_program();
    logic md;
    logic [47:0] gx, gy, ox, oy;
    logic [3:0] cnt;
    longint o;
    md  = 1'($urandom_range(1));
    cnt = ($urandom_range(9) < 7) ? 4'($urandom_range(8, 2)) : 4'($urandom_range(15));
    gx  = pick_gain();
    gy  = pick_gain();
    if (md == 1'b0) begin
      o  = longint'($urandom) - longint'($urandom);
      ox = o[47:0];
      oy = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) : 48'd0;
    end else begin
      // centre somewhere in the frame, or anywhere at all now and then
      o  = longint'($signed(gx)) * $urandom_range(4095);
      ox = ($urandom_range(7) == 0) ? 48'({$urandom, $urandom}) : o[47:0];
      o  = longint'($signed(gy)) * $urandom_range(4095);
      oy = o[47:0];
    end
    program_gradient(md, gx, gy, ox, oy, cnt);
  endtask

  // Mostly keeps the table sorted; one load in five goes anywhere.
  task automatic random_load();
    logic [gfg_pkg::IDX_W-1:0] idx;
    int lo, hi, t;
    idx = 3'($urandom_range(7));
    lo  = (idx == 0) ? 0 : int'(pos_mirror[idx-1]);
    hi  = (idx == 7) ? 65536 : int'(pos_mirror[idx+1]);
    if (lo > hi) begin t = lo; lo = hi; hi = t; end
    if ($urandom_range(4) == 0) load_stop(idx, 17'($urandom_range(65536)), $urandom);
    else load_stop(idx, 17'($urandom_range(hi, lo)), $urandom);
  endtask

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.opcode = gfg_pkg::OP_LOAD;
    cmd_if.stop_index = '0;
    cmd_if.stop_pos = '0;
    cmd_if.stop_rgba = '0;
    cmd_if.pixel_x = '0;
    cmd_if.pixel_y = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = gfg_pkg::REG_MODE;
    cfg_if.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // --- directed ---
    // no stops loaded yet: colour must be zero
    shade_pixel(12'd0, 12'd0);
    shade_pixel(12'hFFF, 12'hFFF);
    // fill the table sorted, slots 3 and 4 sharing a position (flat segment)
    load_stop(3'd0, 17'd0, 32'h0000_0000);
    load_stop(3'd1, 17'd9000, $urandom);
    load_stop(3'd2, 17'd20000, $urandom);
    load_stop(3'd3, 17'd30000, $urandom);
    load_stop(3'd4, 17'd30000, $urandom);
    load_stop(3'd5, 17'd45000, $urandom);
    load_stop(3'd6, 17'd60000, $urandom);
    load_stop(3'd7, 17'd65536, 32'hFFFF_FFFF);
    program_gradient(1'b0, UNIT_SPAN, UNIT_SPAN, 48'd0, 48'd0, 4'd8);
    shade_pixel(12'd0, 12'd0);
    shade_pixel(12'd2048, 12'd1000);
    shade_pixel(12'hFFF, 12'd0);
    shade_pixel(12'hFFF, 12'hFFF);   // clamps to the far end
    // count above table size, with a negative offset
    program_gradient(1'b0, UNIT_SPAN, 48'd0, -48'd200000000, 48'd0, 4'd15);
    shade_pixel(12'd1500, 12'd7);
    // single stop: zero again
    program_gradient(1'b0, UNIT_SPAN, UNIT_SPAN, 48'd0, 48'd0, 4'd1);
    shade_pixel(12'd1000, 12'd1000);
    // radial, centred
    program_gradient(1'b1, 48'd2097152, 48'd2097152, 48'd4294967296, 48'd4294967296, 4'd8);
    shade_pixel(12'd0, 12'd0);
    shade_pixel(12'd2048, 12'd2048);
    shade_pixel(12'hFFF, 12'd1234);
    // extreme gains: magnitude cap in radial, coordinate cap in linear
    program_gradient(1'b1, GAIN_MAX, GAIN_MIN, 48'd0, 48'd0, 4'd8);
    shade_pixel(12'hFFF, 12'hFFF);
    program_gradient(1'b0, GAIN_MAX, GAIN_MAX, GAIN_MIN, GAIN_MIN, 4'd8);
    shade_pixel(12'hFFF, 12'hFFF);

    // --- random: three idling regimes, config reshuffled every 100 requests ---
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 26 : (ph == 1) ? 84 : 0;
      rx_idle = (ph == 0) ? 84 : (ph == 1) ? 26 : 0;
      for (int chunk = 0; chunk < 5; chunk++) begin
        random_program();
        if (ph == 2 && chunk == 2) stall_req = 1'b1;   // long sink hold-off
        for (int i = 0; i < 100; i++) begin
          if ($urandom_range(99) < 85) shade_pixel(12'($urandom), 12'($urandom));
          else random_load();
        end
      end
    end

    settle();
    $display("covered %0d pixels, %0d stop loads, %0d register writes; %0d colours checked",
             n_pixels, n_loads, n_cfg, shaded);
    $display("linear and radial modes, clamped ends, flat segments, idle and stall mixes");
    if (fails == 0) begin
      $display("gradient_fill_generator regression: pass");
    end else begin
      $display("gradient_fill_generator regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("gradient_fill_generator regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
sv/gfg_pkg.sv
sv/gfg_cmd_if.sv
sv/gfg_cfg_if.sv
sv/gfg_color_if.sv
sv/gfg_ram.sv
sv/gradient_fill_generator.sv
sv/gfg_checker.sv
dv/gfg_shade_checker.sv
dv/gradient_fill_generator_tb.sv
